/* rtl/core/tlr_pkg.sv */
// Package: shared constants and types of the thick line rasteriser.
package tlr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int THICK_BITS_DEF = 8;
    localparam int PIX_BITS       = 13;
    localparam int COLOR_BITS     = 32;
    localparam int ERR_BITS       = 16;
    localparam int FIFO_DEPTH     = 2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ADJUST = 2'd1,
        PH_NEXT   = 2'd2,
        PH_DRAW   = 2'd3
    } phase_t;

    typedef enum logic {
        REQ_CMD  = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

endpackage

/* rtl/core/tlr_front.sv */
// Front end: command latch and Bresenham stepping, one tick per beat.
module tlr_front #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        req_type,
    input  logic [COORD_BITS-1:0]       x_start,
    input  logic [COORD_BITS-1:0]       y_start,
    input  logic [COORD_BITS-1:0]       x_end,
    input  logic [COORD_BITS-1:0]       y_end,
    input  logic [THICK_BITS-1:0]       thickness,
    input  logic [31:0]                 line_color,
    output logic                        res_valid,
    output logic [tlr_pkg::PIX_BITS-1:0] res_x,
    output logic [tlr_pkg::PIX_BITS-1:0] res_y,
    output logic [31:0]                 res_color,
    output logic                        res_last
);
    import tlr_pkg::*;

    localparam int CW = PIX_BITS;
    localparam int EW = ERR_BITS;

    phase_t                phase_reg, phase_next;
    logic signed [CW-1:0]  ose_reg [4];
    logic signed [CW-1:0]  ose_next [4];
    logic signed [EW-1:0]  oerr_reg, oerr_next;
    logic [THICK_BITS-1:0] ocnt_reg, ocnt_next;
    logic [THICK_BITS-1:0] lines_reg, lines_next;
    logic [2:0]            sso_reg, sso_next;
    logic [CW-1:0]         adx_reg, adx_next, ady_reg, ady_next;
    logic signed [CW-1:0]  ip_reg [2];
    logic signed [CW-1:0]  ip_next [2];
    logic signed [EW-1:0]  ierr_reg, ierr_next;
    logic                  ovl_reg, ovl_next;
    logic                  pv_reg, pv_next;
    logic signed [CW-1:0]  px_reg, px_next, py_reg, py_next;
    logic [31:0]           col_reg, col_next;

    // derived walk parameters
    logic                  o_maj, i_maj;
    logic signed [CW-1:0]  o_smaj, o_smin, i_smaj, i_smin;
    logic signed [EW-1:0]  o_majd, o_mind, i_majd, i_mind;

    function automatic void derive(
        input  logic [2:0] sso, input logic [CW-1:0] adx, input logic [CW-1:0] ady,
        output logic omaj,
        output logic signed [CW-1:0] osmaj, output logic signed [CW-1:0] osmin,
        output logic signed [EW-1:0] omajd, output logic signed [EW-1:0] omind,
        output logic imaj,
        output logic signed [CW-1:0] ismaj, output logic signed [CW-1:0] ismin,
        output logic signed [EW-1:0] imajd, output logic signed [EW-1:0] imind
    );
        logic nx, ny, sw;
        logic signed [CW-1:0] sx, sy, sxi, syi;
        nx  = sso[0];
        ny  = sso[1];
        sw  = (nx == ny);
        sx  = ny ? -CW'(1) : CW'(1);
        sy  = nx ? -CW'(1) : CW'(1);
        sxi = nx ? -CW'(1) : CW'(1);
        syi = ny ? -CW'(1) : CW'(1);
        if (ady >= adx)
        begin
            omaj  = 1'b0;
            omajd = EW'(ady);
            omind = EW'(adx);
            if (sw)
                sy = -sy;
            else
                sx = -sx;
            osmaj = sx;
            osmin = sy;
        end
        else
        begin
            omaj  = 1'b1;
            omajd = EW'(adx);
            omind = EW'(ady);
            if (sw)
                sx = -sx;
            else
                sy = -sy;
            osmaj = sy;
            osmin = sx;
        end
        if (sso[2])
        begin
            imaj = 1'b0; ismaj = sxi; ismin = syi; imajd = EW'(adx); imind = EW'(ady);
        end
        else
        begin
            imaj = 1'b1; ismaj = syi; ismin = sxi; imajd = EW'(ady); imind = EW'(adx);
        end
    endfunction

    always_comb
    begin
        derive(sso_reg, adx_reg, ady_reg, o_maj, o_smaj, o_smin, o_majd,
               o_mind, i_maj, i_smaj, i_smin, i_majd, i_mind);
    end

    // command decode
    logic signed [CW-1:0]  c_dx, c_dy, c_adx, c_ady;
    logic [2:0]            c_sso;
    logic [THICK_BITS-1:0] c_th, c_adj;
    logic                  c_flip;
    logic signed [EW-1:0]  c_omajd, c_omind;

    always_comb
    begin
        c_dx  = $signed(CW'(x_end)) - $signed(CW'(x_start));
        c_dy  = $signed(CW'(y_end)) - $signed(CW'(y_start));
        c_adx = c_dx[CW-1] ? -c_dx : c_dx;
        c_ady = c_dy[CW-1] ? -c_dy : c_dy;
        c_sso = {(c_adx > c_ady), c_dy[CW-1], c_dx[CW-1]};
        c_th  = (thickness == '0) ? THICK_BITS'(1) : thickness;
        // perpendicular walk: major/minor lengths and whether the split flips
        if (c_ady >= c_adx)
        begin
            c_omajd = EW'(c_ady);
            c_omind = EW'(c_adx);
            c_flip  = (c_dx[CW-1] == c_dy[CW-1]);
        end
        else
        begin
            c_omajd = EW'(c_adx);
            c_omind = EW'(c_ady);
            c_flip  = (c_dx[CW-1] != c_dy[CW-1]);
        end
        c_adj = c_th >> 1;
        if (c_flip)
            c_adj = (c_th - THICK_BITS'(1)) - c_adj;
    end

    always_comb
    begin
        logic mn, last;
        logic signed [CW-1:0] ox, oy;
        logic walk_dir_back, moved;
        phase_next = phase_reg;
        ose_next   = ose_reg;
        oerr_next  = oerr_reg;
        ocnt_next  = ocnt_reg;
        lines_next = lines_reg;
        sso_next   = sso_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        ip_next    = ip_reg;
        ierr_next  = ierr_reg;
        ovl_next   = ovl_reg;
        pv_next    = pv_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        col_next   = col_reg;
        res_valid  = 1'b0;
        res_x      = '0;
        res_y      = '0;
        res_last   = 1'b0;
        mn = ~o_maj;
        last = 1'b0;
        ox = '0;
        oy = '0;
        moved = 1'b0;
        walk_dir_back = 1'b0;

        if (in_valid && req_type == REQ_CMD)
        begin
            col_next   = line_color;
            sso_next   = c_sso;
            adx_next   = c_adx;
            ady_next   = c_ady;
            ose_next[0] = CW'(x_start);
            ose_next[1] = CW'(y_start);
            ose_next[2] = CW'(x_end);
            ose_next[3] = CW'(y_end);
            ocnt_next  = c_adj;
            oerr_next  = (c_omind <<< 1) - c_omajd;
            ovl_next   = 1'b0;
            pv_next    = 1'b0;
            phase_next = PH_ADJUST;
            lines_next = c_th - THICK_BITS'(1);
        end
        else if (in_valid)
        begin
            case (phase_reg)
                PH_ADJUST, PH_NEXT:
                begin
                    walk_dir_back = (phase_reg == PH_ADJUST);
                    if (walk_dir_back && ocnt_reg != '0)
                    begin
                        ose_next[o_maj]     = ose_reg[o_maj] - o_smaj;
                        ose_next[2 + o_maj] = ose_reg[2 + o_maj] - o_smaj;
                        if (!oerr_reg[EW-1])
                        begin
                            ose_next[mn]     = ose_reg[mn] - o_smin;
                            ose_next[2 + mn] = ose_reg[2 + mn] - o_smin;
                            oerr_next = oerr_reg - (o_majd <<< 1) + (o_mind <<< 1);
                        end
                        else
                            oerr_next = oerr_reg + (o_mind <<< 1);
                        ocnt_next = ocnt_reg - THICK_BITS'(1);
                    end
                    else
                    begin
                        if (walk_dir_back)
                        begin
                            ocnt_next = lines_reg;
                            oerr_next = (o_mind <<< 1) - o_majd;
                            ovl_next  = 1'b0;
                        end
                        else
                        begin
                            ose_next[o_maj]     = ose_reg[o_maj] + o_smaj;
                            ose_next[2 + o_maj] = ose_reg[2 + o_maj] + o_smaj;
                            moved = ~oerr_reg[EW-1];
                            if (moved)
                            begin
                                ose_next[mn]     = ose_reg[mn] + o_smin;
                                ose_next[2 + mn] = ose_reg[2 + mn] + o_smin;
                                oerr_next = oerr_reg - (o_majd <<< 1) + (o_mind <<< 1);
                            end
                            else
                                oerr_next = oerr_reg + (o_mind <<< 1);
                            ovl_next = moved;
                            if (ocnt_reg != '0)
                                ocnt_next = ocnt_reg - THICK_BITS'(1);
                        end
                        // start a parallel line at the (new) start point
                        ip_next[0] = ose_next[0];
                        ip_next[1] = ose_next[1];
                        ierr_next  = (i_mind <<< 1) - i_majd;
                        res_valid  = 1'b1;
                        res_x      = ose_next[0];
                        res_y      = ose_next[1];
                        if (ose_next[i_maj] != ose_next[2 + i_maj])
                            phase_next = PH_DRAW;
                        else if (ocnt_next == '0)
                        begin
                            phase_next = PH_IDLE;
                            last = 1'b1;
                        end
                        else
                            phase_next = PH_NEXT;
                        res_last = last;
                    end
                end
                PH_DRAW:
                begin
                    if (pv_reg)
                    begin
                        pv_next   = 1'b0;
                        res_valid = 1'b1;
                        res_x     = px_reg;
                        res_y     = py_reg;
                        if (ip_reg[i_maj] != ose_reg[2 + i_maj])
                            phase_next = PH_DRAW;
                        else if (ocnt_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                            res_last = 1'b1;
                        end
                        else
                            phase_next = PH_NEXT;
                    end
                    else
                    begin
                        ip_next[i_maj] = ip_reg[i_maj] + i_smaj;
                        ox = i_maj ? ip_reg[0] : ip_next[0];
                        oy = i_maj ? ip_next[1] : ip_reg[1];
                        if (!ierr_reg[EW-1])
                        begin
                            ip_next[~i_maj] = ip_reg[~i_maj] + i_smin;
                            ierr_next = ierr_reg - (i_majd <<< 1) + (i_mind <<< 1);
                        end
                        else
                            ierr_next = ierr_reg + (i_mind <<< 1);
                        res_valid = 1'b1;
                        if (!ierr_reg[EW-1] && ovl_reg)
                        begin
                            pv_next = 1'b1;
                            px_next = ip_next[0];
                            py_next = ip_next[1];
                            res_x   = ox;
                            res_y   = oy;
                        end
                        else
                        begin
                            res_x = ip_next[0];
                            res_y = ip_next[1];
                            if (ip_next[i_maj] != ose_reg[2 + i_maj])
                                phase_next = PH_DRAW;
                            else if (ocnt_reg == '0)
                            begin
                                phase_next = PH_IDLE;
                                res_last = 1'b1;
                            end
                            else
                                phase_next = PH_NEXT;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        res_color = col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pv_reg    <= 1'b0;
            ovl_reg   <= 1'b0;
            ocnt_reg  <= '0;
            lines_reg <= '0;
            sso_reg   <= '0;
            adx_reg   <= '0;
            ady_reg   <= '0;
            oerr_reg  <= '0;
            ierr_reg  <= '0;
            col_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pv_reg    <= pv_next;
            ovl_reg   <= ovl_next;
            ocnt_reg  <= ocnt_next;
            lines_reg <= lines_next;
            sso_reg   <= sso_next;
            adx_reg   <= adx_next;
            ady_reg   <= ady_next;
            oerr_reg  <= oerr_next;
            ierr_reg  <= ierr_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ose_reg <= '{default: '0};
            ip_reg  <= '{default: '0};
            px_reg  <= '0;
            py_reg  <= '0;
        end
        else
        begin
            ose_reg <= ose_next;
            ip_reg  <= ip_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
    end

endmodule

/* rtl/core/tlr_queue.sv */
// Result queue: small FIFO between the stepper and the pixel consumer.
module tlr_queue #(
    parameter int WIDTH = 59,
    parameter int DEPTH = tlr_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);
    import tlr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

/* rtl/core/thick_line_rasterizer_core.sv */
// Top level of the thick line rasteriser: stepper plus result FIFO.
//
// Input channel (push/full): a beat with req_type = command latches endpoints,
// thickness and colour and gives no pixel; a beat with req_type = tick advances
// the rasteriser one step and gives at most one pixel. Ticks while idle, and
// the ticks that shift the start point back, give nothing.
// Result channel (empty/pop): pixel_x/pixel_y (two's complement), pixel_color
// and last_pixel, which marks the final pixel of the whole thick line.
// A pixel enters the FIFO as its tick is accepted and is shown once those ahead of it are popped.
// Throughput: one beat per cycle while full is low; the stepper does one Bresenham
// update per tick.
// A two-entry FIFO parts the sides: full rises only when it holds two pixels
// the receiver has not popped; then input beats wait.
// Reset clears the phase to idle, the FIFO to empty and the line state to zero.
module thick_line_rasterizer_core #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         req_type,
    input  logic [COORD_BITS-1:0]        x_start,
    input  logic [COORD_BITS-1:0]        y_start,
    input  logic [COORD_BITS-1:0]        x_end,
    input  logic [COORD_BITS-1:0]        y_end,
    input  logic [THICK_BITS-1:0]        thickness,
    input  logic [31:0]                  line_color,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [tlr_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [tlr_pkg::PIX_BITS-1:0] pixel_y,
    output logic [31:0]                  pixel_color,
    output logic                         last_pixel
);
    import tlr_pkg::*;

    localparam int QW = 2 * PIX_BITS + COLOR_BITS + 1;

    logic                acc;
    logic                res_valid, res_last;
    logic [PIX_BITS-1:0] res_x, res_y;
    logic [31:0]         res_color;
    logic [QW-1:0]       q_out;
    logic                q_rd;

    assign acc  = push && !full;
    assign q_rd = pop && !empty;

    tlr_front #(
        .COORD_BITS(COORD_BITS),
        .THICK_BITS(THICK_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (acc),
        .req_type   (req_type),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .thickness  (thickness),
        .line_color (line_color),
        .res_valid  (res_valid),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_color  (res_color),
        .res_last   (res_last)
    );

    tlr_queue #(
        .WIDTH(QW),
        .DEPTH(FIFO_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data ({res_x, res_y, res_color, res_last}),
        .full    (full),
        .rd_en   (q_rd),
        .empty   (empty),
        .rd_data (q_out)
    );

    assign pixel_x     = q_out[QW-1 -: PIX_BITS];
    assign pixel_y     = q_out[QW-1-PIX_BITS -: PIX_BITS];
    assign pixel_color = q_out[COLOR_BITS:1];
    assign last_pixel  = q_out[0];

    // a pixel is only produced from an accepted tick
    a_res_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (acc && req_type == REQ_TICK))
        else $error("pixel without tick");

    // a command beat never produces a pixel
    a_cmd_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req_type == REQ_CMD) |-> !res_valid)
        else $error("command produced pixel");

    // the FIFO is never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !res_valid)
        else $error("queue overflow");

endmodule

/* tb/sv/tb_thick_line_rasterizer_core.sv */
// Testbench for the thick line rasteriser core: directed and random lines vs a predictor.
module tb_thick_line_rasterizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tlr_pkg::*;

    localparam int CB         = COORD_BITS_DEF;
    localparam int TB         = THICK_BITS_DEF;
    localparam int CMAX       = (1 << CB) - 1;
    localparam int LONG_REACH = 40;
    localparam int STALL_LIMIT = 20000;   // cycles with no beat on either side

    typedef struct {
        logic signed [PIX_BITS-1:0] x;
        logic signed [PIX_BITS-1:0] y;
        logic [31:0]                color;
        logic                       last;
    } pixel_t;

    logic            clk;
    logic            rst_n;
    logic            push;
    logic            full;
    logic            req_type;
    logic [CB-1:0]   x_start, y_start, x_end, y_end;
    logic [TB-1:0]   thickness;
    logic [31:0]     line_color;
    logic            empty;
    logic            pop;
    logic signed [PIX_BITS-1:0] pixel_x, pixel_y;
    logic [31:0]     pixel_color;
    logic            last_pixel;

    thick_line_rasterizer_core uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .x_start(x_start), .y_start(y_start),
        .x_end(x_end), .y_end(y_end), .thickness(thickness),
        .line_color(line_color), .empty(empty), .pop(pop),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
        .last_pixel(last_pixel)
    );

    // Pixels the predictor has produced and the core has not yet delivered.
    pixel_t pixels_due[$];
    int     errors;
    int     beats_sent;
    int     burst_left;
    int     quiet_cycles;

    // ------------------------------------------------------------------
    // Predictor state: current line endpoints, perpendicular walk, inner
    // Bresenham line and the held-back pixel of an overlap step.
    // ------------------------------------------------------------------
    phase_t      ph;
    int          ends [4];        // x0, y0, x1, y1 of the current parallel line
    int          walk_err;
    int          lines_left;      // adjust steps first, then lines still to draw
    bit          neg_x, neg_y, x_major;
    int          adx, ady;
    int          pos [2];
    int          line_err;
    bit          overlap;
    bit          held_valid;
    int          held_x, held_y;
    logic [31:0] colour;

    // perpendicular walk and inner line parameters, derived from octant
    int w_maj, w_smaj, w_smin, w_majd, w_mind;
    bit w_flip;
    int l_maj, l_smaj, l_smin, l_majd, l_mind;

    function automatic void derive_steps();
        int  sx, sy;
        bit  swap;
        sx   = neg_y ? -1 : 1;
        sy   = neg_x ? -1 : 1;
        swap = (neg_x == neg_y);
        if (ady >= adx)
        begin
            w_maj = 0; w_majd = ady; w_mind = adx;
            if (swap)
            begin
                sy = -sy; w_flip = 1;
            end
            else
            begin
                sx = -sx; w_flip = 0;
            end
            w_smaj = sx; w_smin = sy;
        end
        else
        begin
            w_maj = 1; w_majd = adx; w_mind = ady;
            if (swap)
            begin
                sx = -sx; w_flip = 0;
            end
            else
            begin
                sy = -sy; w_flip = 1;
            end
            w_smaj = sy; w_smin = sx;
        end
        if (x_major)
        begin
            l_maj = 0; l_smaj = neg_x ? -1 : 1; l_smin = neg_y ? -1 : 1;
            l_majd = adx; l_mind = ady;
        end
        else
        begin
            l_maj = 1; l_smaj = neg_y ? -1 : 1; l_smin = neg_x ? -1 : 1;
            l_majd = ady; l_mind = adx;
        end
    endfunction

    function automatic void emit_pixel(int px, int py, bit last);
        pixel_t p;
        p.x     = PIX_BITS'(px);
        p.y     = PIX_BITS'(py);
        p.color = colour;
        p.last  = last;
        pixels_due.push_back(p);
    endfunction

    // one perpendicular step; returns 1 when it also moved in the minor axis
    function automatic bit perp_step(int dir);
        bit moved;
        moved = 0;
        ends[w_maj]     += dir * w_smaj;
        ends[2 + w_maj] += dir * w_smaj;
        if (walk_err >= 0)
        begin
            ends[1 - w_maj] += dir * w_smin;
            ends[3 - w_maj] += dir * w_smin;
            walk_err -= 2 * w_majd;
            moved = 1;
        end
        walk_err += 2 * w_mind;
        return moved;
    endfunction

    // after a regular pixel: decide the next phase, returns the last mark
    function automatic bit after_pixel();
        if (pos[l_maj] != ends[2 + l_maj])
        begin
            ph = PH_DRAW;
            return 0;
        end
        if (lines_left == 0)
        begin
            ph = PH_IDLE;
            return 1;
        end
        ph = PH_NEXT;
        return 0;
    endfunction

    function automatic void begin_parallel();
        pos[0]   = ends[0];
        pos[1]   = ends[1];
        line_err = 2 * l_mind - l_majd;
        emit_pixel(pos[0], pos[1], after_pixel());
    endfunction

    function automatic void predictor_reset();
        ph = PH_IDLE;
        ends = '{0, 0, 0, 0};
        walk_err = 0; lines_left = 0;
        neg_x = 0; neg_y = 0; x_major = 0;
        adx = 0; ady = 0;
        pos = '{0, 0};
        line_err = 0; overlap = 0;
        held_valid = 0; held_x = 0; held_y = 0;
        colour = '0;
        derive_steps();
    endfunction

    function automatic void predict_beat(req_t rq, int xs, int ys, int xe, int ye,
                                         int th, logic [31:0] col);
        int dx, dy, adj, ox, oy;
        if (rq == REQ_CMD)
        begin
            if (th < 1)
                th = 1;
            colour  = col;
            dx      = xe - xs;
            dy      = ye - ys;
            neg_x   = dx < 0;
            neg_y   = dy < 0;
            adx     = neg_x ? -dx : dx;
            ady     = neg_y ? -dy : dy;
            x_major = adx > ady;
            ends    = '{xs, ys, xe, ye};
            derive_steps();
            adj = th / 2;
            if (w_flip)
                adj = (th - 1) - adj;
            lines_left = adj;
            walk_err   = 2 * w_mind - w_majd;
            overlap    = 0;
            held_valid = 0;
            ph         = PH_ADJUST;
            line_err   = th - 1;       // line count parked until adjust is done
            return;
        end
        case (ph)
            PH_ADJUST:
            begin
                if (lines_left > 0)
                begin
                    void'(perp_step(-1));
                    lines_left--;
                end
                else
                begin
                    lines_left = line_err;
                    walk_err   = 2 * w_mind - w_majd;
                    overlap    = 0;
                    begin_parallel();
                end
            end
            PH_NEXT:
            begin
                overlap = perp_step(1);
                if (lines_left > 0)
                    lines_left--;
                begin_parallel();
            end
            PH_DRAW:
            begin
                if (held_valid)
                begin
                    held_valid = 0;
                    emit_pixel(held_x, held_y, after_pixel());
                    return;
                end
                pos[l_maj] += l_smaj;
                if (line_err >= 0)
                begin
                    ox = pos[0];
                    oy = pos[1];
                    pos[1 - l_maj] += l_smin;
                    line_err += 2 * l_mind - 2 * l_majd;
                    if (overlap)
                    begin
                        // overlap pixel first, the regular one follows next tick
                        held_valid = 1;
                        held_x = pos[0];
                        held_y = pos[1];
                        emit_pixel(ox, oy, 0);
                        return;
                    end
                end
                else
                    line_err += 2 * l_mind;
                emit_pixel(pos[0], pos[1], after_pixel());
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, result checking, receiver stalls and the watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pixels_due.size() == 0)
                begin
                    $error("pixel beat with none expected: x=%0d y=%0d", pixel_x, pixel_y);
                    errors++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (pixel_x !== want.x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
                        errors++;
                    end
                    if (pixel_y !== want.y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
                        errors++;
                    end
                    if (pixel_color !== want.color)
                    begin
                        $error("pixel_color: expected %h, got %h", want.color, pixel_color);
                        errors++;
                    end
                    if (last_pixel !== want.last)
                    begin
                        $error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
                        errors++;
                    end
                end
            end
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else if (++quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: stall mode is redrawn at random, ranging from never
    // stalling to stalling most of the time.
    int pop_mode;
    int pop_cycle;
    always @(posedge clk)
    begin
        if (pop_cycle % 256 == 0)
            pop_mode = $urandom_range(0, 3);
        pop_cycle++;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            2:       pop <= ($urandom_range(0, 7) == 0);
            default: pop <= ((pop_cycle / 8) % 2 == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender: one beat, in bursts with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_beat(req_t rq, int xs, int ys, int xe, int ye, int th,
                             logic [31:0] col);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        push       <= 1'b1;
        req_type   <= rq;
        x_start    <= CB'(xs);
        y_start    <= CB'(ys);
        x_end      <= CB'(xe);
        y_end      <= CB'(ye);
        thickness  <= TB'(th);
        line_color <= col;
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats_sent++;
        predict_beat(rq, xs, ys, xe, ye, th, col);
    endtask

    // tick beat: the unused fields carry noise
    task automatic send_tick();
        send_beat(REQ_TICK, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                  $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                  $urandom_range(0, (1 << TB) - 1), $urandom);
    endtask

    // command, then ticks until the whole thick line is out
    task automatic draw_line(int xs, int ys, int xe, int ye, int th, logic [31:0] col);
        send_beat(REQ_CMD, xs, ys, xe, ye, th, col);
        while (ph != PH_IDLE)
            send_tick();
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        burst_left = 0;
        while (pixels_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic int clamp_coord(int v);
        return v < 0 ? 0 : (v > CMAX ? CMAX : v);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_thin_and_degenerate();
        send_tick();                                    // idle tick
        draw_line(100, 100, 100, 100, 0, 32'h0000_0000); // zero length, thickness 0
        draw_line(5, 7, 12, 9, 1, 32'hFFFF_FFFF);
        draw_line(50, 50, 50, 50, 9, 32'h1234_5678);    // zero length, thick
        send_tick();
    endtask

    task automatic test_octants();
        // eight octants around a centre, thickness even and odd
        draw_line(400, 400, 405, 402, 3, 32'hA5A5_0001);
        draw_line(400, 400, 402, 405, 2, 32'hA5A5_0002);
        draw_line(400, 400, 398, 405, 3, 32'hA5A5_0003);
        draw_line(400, 400, 395, 402, 2, 32'hA5A5_0004);
        draw_line(400, 400, 395, 398, 3, 32'hA5A5_0005);
        draw_line(400, 400, 398, 395, 2, 32'hA5A5_0006);
        draw_line(400, 400, 402, 395, 3, 32'hA5A5_0007);
        draw_line(400, 400, 405, 398, 4, 32'hA5A5_0008);
        draw_line(300, 300, 304, 304, 3, 32'h0F0F_0F0F);  // exact diagonal
    endtask

    task automatic test_extremes();
        draw_line(CMAX - 6, CMAX - 6, CMAX, CMAX, 1, 32'hFFFF_FFFF);
        draw_line(CMAX, 0, CMAX - 8, 3, 2, 32'h8000_0001);
        draw_line(0, 0, 1, 0, 40, 32'h7FFF_FFFE);        // goes off screen
        draw_line(CMAX, CMAX, CMAX - 2, CMAX, 6, 32'h5555_AAAA);
        wait_drained();
    endtask

    task automatic test_command_while_busy();
        int n;
        send_beat(REQ_CMD, 20, 30, 40, 35, 6, 32'hDEAD_BEEF);
        for (n = 0; n < 15; n++)
            send_tick();
        draw_line(600, 10, 590, 25, 3, 32'hCAFE_0000);
    endtask

    task automatic test_random(int beat_goal);
        int  xs, ys, xe, ye, th, reach, n, start_beats, next_drain;
        start_beats = beats_sent;
        next_drain  = beats_sent + 150;
        while (beats_sent - start_beats < beat_goal)
        begin
            xs = $urandom_range(0, CMAX);
            ys = $urandom_range(0, CMAX);
            reach = ($urandom_range(0, 49) == 0) ? LONG_REACH : 12;
            xe = clamp_coord(xs + $urandom_range(0, 2 * reach) - reach);
            ye = clamp_coord(ys + $urandom_range(0, 2 * reach) - reach);
            if (reach == LONG_REACH)
                th = $urandom_range(0, 2);
            else if ($urandom_range(0, 19) == 0)
            begin
                th = $urandom_range(8, 31);
                xe = clamp_coord(xs + $urandom_range(0, 4) - 2);
                ye = clamp_coord(ys + $urandom_range(0, 4) - 2);
            end
            else
                th = $urandom_range(0, 7);
            if ($urandom_range(0, 4) != 0)
                draw_line(xs, ys, xe, ye, th, $urandom);
            else
            begin
                // broken sequence: cut short by the next command
                send_beat(REQ_CMD, xs, ys, xe, ye, th, $urandom);
                n = $urandom_range(0, 20);
                repeat (n) send_tick();
            end
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) send_tick();
            if (beats_sent >= next_drain)
            begin
                wait_drained();
                next_drain = beats_sent + 150;
            end
        end
    endtask

    initial
    begin
        errors = 0; beats_sent = 0; burst_left = 0; quiet_cycles = 0;
        pop_mode = 0; pop_cycle = 0;
        rst_n = 1'b0;
        push = 1'b0; pop = 1'b0; req_type = REQ_CMD;
        x_start = '0; y_start = '0; x_end = '0; y_end = '0;
        thickness = '0; line_color = '0;
        predictor_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_thin_and_degenerate();
        test_octants();
        test_extremes();
        test_command_while_busy();
        test_random(200);

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && pixels_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
